FILE: sv/ptfe_pkg.sv
// Package for the peer table: table size, derived widths, action codes and
// the command record that passes from the classifier to the table updater.
// No dependencies.
package ptfe_pkg;

  localparam int MAX_PEERS = 8;
  localparam int SLOT_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CNT_W     = $clog2(MAX_PEERS + 1);

  typedef enum logic [1:0] {
    ACT_IGNORE = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_EVICT  = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       peer_id;
    logic [31:0]       peer_address;
    logic [15:0]       peer_port;
    logic [31:0]       now_ms;
  } cmd_t;

endpackage

FILE: sv/ptfe_front.sv
// Front end of the peer table: takes sightings, holds the own identifier and
// classifies each sighting against the stored identifiers.
// Depends on ptfe_pkg.
module ptfe_front import ptfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [31:0]       peer_id_i,
  input  logic [31:0]       peer_address_i,
  input  logic [15:0]       peer_port_i,
  input  logic [31:0]       now_ms_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       cfg_data_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       entry_id_i [MAX_PEERS],
  input  logic [CNT_W-1:0]  count_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic [31:0]       local_id_q;
  logic              found;
  logic [SLOT_W-1:0] hit_slot;

  assign cfg_ready_o = 1'b1;
  assign push_o      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      local_id_q <= cfg_data_i;
    end
  end

  // Scan from the top down so that the lowest matching slot wins.
  always_comb begin
    found    = 1'b0;
    hit_slot = '0;
    for (int k = MAX_PEERS - 1; k >= 0; k--) begin
      if ((CNT_W'(k) < count_i) && (entry_id_i[k] == peer_id_i)) begin
        found    = 1'b1;
        hit_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    cmd_o.peer_id      = peer_id_i;
    cmd_o.peer_address = peer_address_i;
    cmd_o.peer_port    = peer_port_i;
    cmd_o.now_ms       = now_ms_i;
    if (peer_id_i == local_id_q) begin
      cmd_o.action = ACT_IGNORE;
      cmd_o.slot   = '0;
    end else if (found) begin
      cmd_o.action = ACT_UPDATE;
      cmd_o.slot   = hit_slot;
    end else if (count_i == CNT_W'(MAX_PEERS)) begin
      cmd_o.action = ACT_EVICT;
      cmd_o.slot   = SLOT_W'(MAX_PEERS - 1);
    end else begin
      cmd_o.action = ACT_INSERT;
      cmd_o.slot   = SLOT_W'(count_i);
    end
  end

endmodule

FILE: sv/ptfe_queue.sv
// Two-entry command queue between the classifier and the table updater.
// Depends on ptfe_pkg.
module ptfe_queue import ptfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;

  assign valid_o = (fill_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/ptfe_back.sv
// Back end of the peer table: holds the entries and the valid count, carries
// out each classified command and registers the result.
// Depends on ptfe_pkg.
module ptfe_back import ptfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic [31:0]      entry_id_o [MAX_PEERS],
  output logic [CNT_W-1:0] count_o,
  output logic             done_o,
  output logic [1:0]       action_o,
  output logic [2:0]       slot_o,
  output logic [31:0]      packet_count_o,
  output logic [3:0]       peer_count_o
);

  logic [31:0]       id_q      [MAX_PEERS];
  logic [31:0]       addr_q    [MAX_PEERS];
  logic [15:0]       port_q    [MAX_PEERS];
  logic [31:0]       seen_q    [MAX_PEERS];
  logic [31:0]       pk_q      [MAX_PEERS];
  logic [31:0]       id_d      [MAX_PEERS];
  logic [31:0]       addr_d    [MAX_PEERS];
  logic [15:0]       port_d    [MAX_PEERS];
  logic [31:0]       seen_d    [MAX_PEERS];
  logic [31:0]       pk_d      [MAX_PEERS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [31:0]       res_pk;
  logic              done_q;
  action_e           action_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       pk_out_q;
  logic [CNT_W-1:0]  peers_q;

  assign pop_o      = cmd_valid_i;
  assign entry_id_o = id_q;
  assign count_o    = count_q;

  always_comb begin
    id_d    = id_q;
    addr_d  = addr_q;
    port_d  = port_q;
    seen_d  = seen_q;
    pk_d    = pk_q;
    count_d = count_q;
    res_pk  = 32'd0;
    case (cmd_i.action)
      ACT_UPDATE: begin
        res_pk               = pk_q[cmd_i.slot] + 32'd1;
        addr_d[cmd_i.slot]   = cmd_i.peer_address;
        port_d[cmd_i.slot]   = cmd_i.peer_port;
        seen_d[cmd_i.slot]   = cmd_i.now_ms;
        pk_d[cmd_i.slot]     = res_pk;
      end
      ACT_INSERT: begin
        res_pk               = 32'd1;
        id_d[cmd_i.slot]     = cmd_i.peer_id;
        addr_d[cmd_i.slot]   = cmd_i.peer_address;
        port_d[cmd_i.slot]   = cmd_i.peer_port;
        seen_d[cmd_i.slot]   = cmd_i.now_ms;
        pk_d[cmd_i.slot]     = 32'd1;
        count_d              = count_q + CNT_W'(1);
      end
      ACT_EVICT: begin
        // The oldest entry sits in slot zero; everything moves down one place.
        res_pk = 32'd1;
        for (int k = 0; k < MAX_PEERS - 1; k++) begin
          id_d[k]   = id_q[k+1];
          addr_d[k] = addr_q[k+1];
          port_d[k] = port_q[k+1];
          seen_d[k] = seen_q[k+1];
          pk_d[k]   = pk_q[k+1];
        end
        id_d[MAX_PEERS-1]   = cmd_i.peer_id;
        addr_d[MAX_PEERS-1] = cmd_i.peer_address;
        port_d[MAX_PEERS-1] = cmd_i.peer_port;
        seen_d[MAX_PEERS-1] = cmd_i.now_ms;
        pk_d[MAX_PEERS-1]   = 32'd1;
      end
      default: begin
        res_pk = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= pop_o;
      if (pop_o) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      id_q     <= id_d;
      addr_q   <= addr_d;
      port_q   <= port_d;
      seen_q   <= seen_d;
      pk_q     <= pk_d;
      action_q <= cmd_i.action;
      slot_q   <= cmd_i.slot;
      pk_out_q <= res_pk;
      peers_q  <= count_d;
    end
  end

  assign done_o         = done_q;
  assign action_o       = 2'(action_q);
  assign slot_o         = 3'(slot_q);
  assign packet_count_o = pk_out_q;
  assign peer_count_o   = 4'(peers_q);

endmodule

FILE: sv/peer_table_fifo_evict_top.sv
// Top level of the peer table with oldest-first eviction.
// Depends on ptfe_pkg, ptfe_front, ptfe_queue and ptfe_back.
//
//   channel   | transfer when          | payload
//   ----------+------------------------+-------------------------------------------
//   sighting  | start && !busy         | peer_id_i, peer_address_i, peer_port_i, now_ms_i
//   result    | done_o (one cycle)     | action_o, slot_o, packet_count_o, peer_count_o
//   config    | cfg_valid_i && ready   | cfg_data_i (own identifier)
//
// A sighting is classified in the cycle it is taken and queued; the table is
// written in the next cycle, so busy is high for one cycle and no new sighting
// is taken until busy falls. The result appears in the cycle after the table
// write, for one cycle only. Reset empties the table and clears the own
// identifier to zero. The result side never stalls; cfg_ready_o is always high.
module peer_table_fifo_evict_top import ptfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] peer_id_i,
  input  logic [31:0] peer_address_i,
  input  logic [15:0] peer_port_i,
  input  logic [31:0] now_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  action_o,
  output logic [2:0]  slot_o,
  output logic [31:0] packet_count_o,
  output logic [3:0]  peer_count_o
);

  logic             push;
  cmd_t             cmd_in;
  logic             q_valid;
  cmd_t             cmd_out;
  logic             pop;
  logic [31:0]      entry_id [MAX_PEERS];
  logic [CNT_W-1:0] count;

  // Busy while a command waits, so the classifier always sees a settled table.
  assign busy = q_valid;

  ptfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .peer_id_i      (peer_id_i),
    .peer_address_i (peer_address_i),
    .peer_port_i    (peer_port_i),
    .now_ms_i       (now_ms_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .entry_id_i     (entry_id),
    .count_i        (count),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  ptfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  ptfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .entry_id_o     (entry_id),
    .count_o        (count),
    .done_o         (done_o),
    .action_o       (action_o),
    .slot_o         (slot_o),
    .packet_count_o (packet_count_o),
    .peer_count_o   (peer_count_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted sighting did not raise busy");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted sighting gave no result two cycles later");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe out of step with busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(MAX_PEERS))
    else $error("peer count exceeds table size");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for peer_table_fifo_evict_top: a directed opening, then
// random sightings over several own-identifier settings and sender idle rates.
// Depends on ptfe_pkg and the RTL of the peer table.
module testbench;
  import ptfe_pkg::*;

  typedef struct packed {
    logic [31:0] peer_id;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [31:0] now_ms;
  } sighting_t;

  typedef struct packed {
    action_e     action;
    logic [2:0]  slot;
    logic [31:0] packets;
    logic [3:0]  peers;
  } outcome_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [31:0] peer_id_i      = '0;
  logic [31:0] peer_address_i = '0;
  logic [15:0] peer_port_i    = '0;
  logic [31:0] now_ms_i       = '0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i     = '0;
  logic        done_o;
  logic [1:0]  action_o;
  logic [2:0]  slot_o;
  logic [31:0] packet_count_o;
  logic [3:0]  peer_count_o;

  peer_table_fifo_evict_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .peer_id_i      (peer_id_i),
    .peer_address_i (peer_address_i),
    .peer_port_i    (peer_port_i),
    .now_ms_i       (now_ms_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .action_o       (action_o),
    .slot_o         (slot_o),
    .packet_count_o (packet_count_o),
    .peer_count_o   (peer_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: only identifiers and packet counts; addresses, ports and times never reach the outputs.
  logic [31:0] own_id = '0;
  logic [31:0] tbl_id      [MAX_PEERS];
  logic [31:0] tbl_packets [MAX_PEERS];
  int          peers_held = 0;

  sighting_t   sighting_q[$];
  outcome_t    outcome_q[$];
  sighting_t   on_port;
  outcome_t    want;
  int          idle_pct = 0;
  int          mismatch_n = 0;
  logic [31:0] id_pool[12];

  function automatic outcome_t apply_sighting(sighting_t s);
    outcome_t o;
    int       hit;
    int       k;
    o.action  = ACT_IGNORE;
    o.slot    = '0;
    o.packets = '0;
    hit       = -1;
    if (s.peer_id != own_id) begin
      for (k = 0; k < peers_held; k++)
        if (hit < 0 && tbl_id[k] == s.peer_id) hit = k;
      if (hit >= 0) begin
        tbl_packets[hit] = tbl_packets[hit] + 32'd1;
        o.action  = ACT_UPDATE;
        o.slot    = hit[2:0];
        o.packets = tbl_packets[hit];
      end else begin
        o.action = ACT_INSERT;
        if (peers_held >= MAX_PEERS) begin
          // The oldest entry sits in slot 0; everything moves down one place.
          for (k = 0; k + 1 < MAX_PEERS; k++) begin
            tbl_id[k]      = tbl_id[k + 1];
            tbl_packets[k] = tbl_packets[k + 1];
          end
          peers_held = MAX_PEERS - 1;
          o.action   = ACT_EVICT;
        end
        tbl_id[peers_held]      = s.peer_id;
        tbl_packets[peers_held] = 32'd1;
        o.slot    = peers_held[2:0];
        o.packets = 32'd1;
        peers_held++;
      end
    end
    o.peers = peers_held[3:0];
    return o;
  endfunction

  function automatic sighting_t random_sighting();
    sighting_t s;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 80)      s.peer_id = id_pool[$urandom_range(11)];
    else if (pick < 88) s.peer_id = own_id;
    else                s.peer_id = $urandom;
    s.peer_address = $urandom;
    s.peer_port    = 16'($urandom);
    s.now_ms       = $urandom;
    return s;
  endfunction

  task automatic add_sighting(logic [31:0] id, logic [31:0] addr, logic [15:0] port,
                              logic [31:0] stamp);
    sighting_q.push_back('{id, addr, port, stamp});
  endtask

  task automatic wait_drained();
    while (sighting_q.size() != 0 || outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_own_id(logic [31:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_id = value;
  endtask

  // Driver: start stays high until the transfer, then the next sighting or a gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcome_q.push_back(apply_sighting(on_port));
      if (!start || !busy) begin
        if (sighting_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_port = sighting_q.pop_front();
          peer_id_i      <= on_port.peer_id;
          peer_address_i <= on_port.peer_address;
          peer_port_i    <= on_port.peer_port;
          now_ms_i       <= on_port.now_ms;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= 10)
          $display("unexpected result: action %0d slot %0d packets %0d peers %0d",
                   action_o, slot_o, packet_count_o, peer_count_o);
      end else begin
        want = outcome_q.pop_front();
        if (action_o !== want.action || slot_o !== want.slot ||
            packet_count_o !== want.packets || peer_count_o !== want.peers) begin
          mismatch_n++;
          if (mismatch_n <= 10) begin
            $write("result mismatch: expected action %0d slot %0d packets %0d peers %0d,",
                   want.action, want.slot, want.packets, want.peers);
            $display(" got action %0d slot %0d packets %0d peers %0d",
                     action_o, slot_o, packet_count_o, peer_count_o);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] own_plan[6];
    int          idle_plan[6];
    int          ph;
    int          k;
    int          counted;
    sighting_t   s;

    own_plan  = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
    idle_plan = '{0, 62, 19, 0, 62, 19};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Own identifier is zero after reset, so this first sighting is ignored.
    add_sighting(32'h0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_sighting(32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0);
    add_sighting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (k = 1; k < MAX_PEERS; k++) add_sighting(k, $urandom, 16'($urandom), $urandom);
    add_sighting(32'd8, 32'h0A00_0001, 16'd5000, 32'd100);
    add_sighting(32'd1, 32'h0A00_0002, 16'd5001, 32'd101);
    add_sighting(32'hFFFF_FFFF, 32'h0A00_0003, 16'd5002, 32'd102);
    wait_drained();

    // A peer already in the table becomes the own identifier and is then ignored.
    write_own_id(32'd5);
    add_sighting(32'd5, 32'h1234_5678, 16'h8000, 32'h8000_0000);
    add_sighting(32'd0, 32'h5555_5555, 16'h5555, 32'hAAAA_AAAA);
    add_sighting(32'd6, 32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      for (k = 0; k < 12; k++) id_pool[k] = $urandom;
      if (ph == 3) begin
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
      end
      if (ph == 1 || ph == 4) own_plan[ph] = $urandom;
      if (ph == 2) own_plan[ph] = id_pool[0];
      write_own_id(own_plan[ph]);
      idle_pct = idle_plan[ph];
      counted  = 0;
      while (counted < 250) begin
        s = random_sighting();
        sighting_q.push_back(s);
        if (s.peer_id != own_id) counted++;
      end
      // Every phase ends with the sender held back until all results are in.
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_n == 0 && outcome_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/ptfe_pkg.sv
sv/ptfe_front.sv
sv/ptfe_queue.sv
sv/ptfe_back.sv
sv/peer_table_fifo_evict_top.sv
tb/sv/testbench.sv
